FILE: hdl/bdda_pkg.sv
// Shared types, constants and calendar helpers for the business day date adder.
// Used by the front, queue, back and top level modules; depends on nothing.
package bdda_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 16;
  localparam int unsigned WdW    = 3;
  localparam int unsigned R400W  = 9;

  localparam logic [YearW-1:0]  YearMax  = '1;
  localparam logic [MonthW-1:0] December = 4'd12;
  localparam logic [R400W-1:0]  R400Last = 9'd399;
  localparam logic [WdW-1:0]    Friday   = 3'd5;
  localparam logic [WdW-1:0]    Saturday = 3'd6;

  typedef struct packed {
    logic [YearW-1:0]  start_year;
    logic [MonthW-1:0] start_month;
    logic [DayW-1:0]   start_day;
    logic [CountW-1:0] business_days;
  } req_t;

  typedef struct packed {
    logic [YearW-1:0]  end_year;
    logic [MonthW-1:0] end_month;
    logic [DayW-1:0]   end_day;
    logic              bad_date;
  } rsp_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [CountW-1:0] count;
    logic [WdW-1:0]    weekday;
    logic [R400W-1:0]  year_mod400;
    logic              bad;
  } job_t;

  // Leap rule from year mod 400.
  function automatic logic is_leap(input logic [R400W-1:0] r400);
    is_leap = (r400[1:0] == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200) &&
              (r400 != 9'd300);
  endfunction

  // Month length; zero for month codes outside January..December.
  function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] m,
                                                    input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    days_in_month = len;
  endfunction

  // floor(31 * mm / 12) for the shifted month (March is 1).
  function automatic logic [DayW-1:0] month_offset(input logic [MonthW-1:0] mm);
    logic [DayW-1:0] off;
    case (mm)
      4'd1:    off = 5'd2;
      4'd2:    off = 5'd5;
      4'd3:    off = 5'd7;
      4'd4:    off = 5'd10;
      4'd5:    off = 5'd12;
      4'd6:    off = 5'd15;
      4'd7:    off = 5'd18;
      4'd8:    off = 5'd20;
      4'd9:    off = 5'd23;
      4'd10:   off = 5'd25;
      4'd11:   off = 5'd28;
      4'd12:   off = 5'd31;
      default: off = 5'd0;
    endcase
    month_offset = off;
  endfunction

endpackage

FILE: hdl/business_day_date_adder.sv
// Business day date adder: takes a Gregorian start date and a count of
// business days (any day but Friday and Saturday) and returns the date reached.
// The front end checks each word's date and derives the start weekday
// through reciprocal multiplies; the back end then steps one calendar day
// per cycle, and that day-step loop sets the throughput.
// A short queue between them lets the next word be checked while the current
// one is walked. An invalid start date sets bad_date and is returned unchanged.
// Depends on bdda_pkg, bdda_front, bdda_queue and bdda_back.
module business_day_date_adder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bdda_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bdda_pkg::rsp_t rsp
);

  bdda_pkg::job_t front_job, back_job;
  logic           push, full, pop, empty;

  bdda_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .job       (front_job),
    .full      (full)
  );

  bdda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (front_job),
    .full   (full),
    .pop    (pop),
    .rd_job (back_job),
    .empty  (empty)
  );

  bdda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .empty     (empty),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: hdl/bdda_front.sv
// Front end: accepts a request word, checks the date and derives the start
// weekday and year mod 400 in its Q100, SUM and Q7 states. Depends on bdda_pkg.
module bdda_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bdda_pkg::req_t req,
  output logic           push,
  output bdda_pkg::job_t job,
  input  logic           full
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_Q100 = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_Q7   = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0]  state, state_next;

  logic [13:0] year, yy;
  logic [3:0]  month, mm;
  logic [4:0]  day;
  logic [15:0] count;
  logic [7:0]  q100y, q100yy;
  logic [14:0] wsum;
  logic [8:0]  r400;
  logic        bad;
  logic [12:0] q7;

  logic        shift_a;
  logic [26:0] prod_y, prod_yy;
  logic [13:0] r400_full;
  logic [4:0]  dim;
  logic        valid_date;
  logic [14:0] wsum_c;
  logic [30:0] prod_7;
  logic [15:0] seven_q, wd_diff;

  assign shift_a = (req.start_month <= 4'd2);

  // Divide by 100 through a reciprocal; exact for 14-bit values.
  assign prod_y  = {13'd0, year} * 27'd5243;
  assign prod_yy = {13'd0, yy} * 27'd5243;

  assign r400_full  = year - 14'({q100y[7:2], 8'd0} + {q100y[7:2], 7'd0} +
                                 {q100y[7:2], 4'd0});
  assign dim        = bdda_pkg::days_in_month(month, bdda_pkg::is_leap(r400_full[8:0]));
  assign valid_date = (year != 14'd0) && (month >= 4'd1) && (month <= bdda_pkg::December) &&
                      (day != 5'd0) && (day <= dim);
  assign wsum_c = 15'(day) + 15'(yy) + 15'(yy[13:2]) - 15'(q100yy) + 15'(q100yy[7:2]) +
                  15'(bdda_pkg::month_offset(mm));

  // Divide by 7 through a reciprocal; exact below 2^15.
  assign prod_7  = {16'd0, wsum} * 31'd37450;
  assign seven_q = 16'({q7, 3'd0}) - 16'(q7);
  assign wd_diff = 16'(wsum) - seven_q;

  assign req_stall = (state != S_IDLE);
  assign push      = (state == S_PUSH) && !full;

  always_comb begin
    job.year        = year;
    job.month       = month;
    job.day         = day;
    job.count       = count;
    job.weekday     = wd_diff[2:0];
    job.year_mod400 = r400;
    job.bad         = bad;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req_valid) state_next = S_Q100;
      S_Q100:  state_next = S_SUM;
      S_SUM:   state_next = S_Q7;
      S_Q7:    state_next = S_PUSH;
      S_PUSH:  if (!full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      year  <= req.start_year;
      month <= req.start_month;
      day   <= req.start_day;
      count <= req.business_days;
      yy    <= req.start_year - 14'(shift_a);
      mm    <= shift_a ? 4'(req.start_month + 4'd10) : 4'(req.start_month - 4'd2);
    end
    if (state == S_Q100) begin
      q100y  <= prod_y[26:19];
      q100yy <= prod_yy[26:19];
    end
    if (state == S_SUM) begin
      wsum <= wsum_c;
      r400 <= r400_full[8:0];
      bad  <= !valid_date;
    end
    if (state == S_Q7) begin
      q7 <= prod_7[30:18];
    end
  end

endmodule

FILE: hdl/bdda_queue.sv
// Short queue of classified words between front and back.
// Depends on bdda_pkg for the entry type.
module bdda_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bdda_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output bdda_pkg::job_t rd_job,
  output logic           empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bdda_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  fill;

  assign full   = (fill == CW'(DEPTH));
  assign empty  = (fill == '0);
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

FILE: hdl/bdda_back.sv
// Back end: walks the calendar one day per cycle until the business day count is
// used up (bad or zero-count words skip the walk), then loads the output register. Depends on bdda_pkg.
module bdda_back (
  input  logic           clk,
  input  logic           rst,
  input  bdda_pkg::job_t job,
  input  logic           empty,
  output logic           pop,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bdda_pkg::rsp_t rsp
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]  state, state_next;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [15:0] count, count_next;
  logic [2:0]  weekday;
  logic [8:0]  r400;
  logic        bad;

  logic        out_free;
  logic        last_day;
  logic        workday;

  assign out_free = !rsp_valid || !rsp_stall;
  assign pop      = (state == B_IDLE) && !empty;
  assign last_day = (day == bdda_pkg::days_in_month(month, bdda_pkg::is_leap(r400)));
  assign workday  = (weekday != bdda_pkg::Friday) && (weekday != bdda_pkg::Saturday);

  always_comb begin
    count_next = workday ? count - 16'd1 : count;
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          state_next = (job.bad || job.count == '0) ? B_DONE : B_RUN;
        end
      end
      B_RUN:   if (count_next == '0) state_next = B_DONE;
      B_DONE:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      year    <= job.year;
      month   <= job.month;
      day     <= job.day;
      count   <= job.count;
      weekday <= job.weekday;
      r400    <= job.year_mod400;
      bad     <= job.bad;
    end else if (state == B_RUN) begin
      count   <= count_next;
      weekday <= (weekday == bdda_pkg::Saturday) ? 3'd0 : weekday + 3'd1;
      if (last_day) begin
        day <= 5'd1;
        if (month == bdda_pkg::December) begin
          month <= 4'd1;
          year  <= year + 14'd1;
          // the year counter wraps to zero, which is a multiple of 400
          r400  <= (year == bdda_pkg::YearMax || r400 == bdda_pkg::R400Last) ?
                   9'd0 : r400 + 9'd1;
        end else begin
          month <= month + 4'd1;
        end
      end else begin
        day <= day + 5'd1;
      end
    end
    if (state == B_DONE && out_free) begin
      rsp.end_year  <= year;
      rsp.end_month <= month;
      rsp.end_day   <= day;
      rsp.bad_date  <= bad;
    end
  end

  a_run_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == B_RUN |-> count != '0)
    else $error("day walk running with an exhausted count");

  a_run_date_sane: assert property (@(posedge clk) disable iff (rst)
    state == B_RUN |-> (day != 5'd0 && month >= 4'd1 && month <= bdda_pkg::December &&
                        weekday != 3'd7))
    else $error("day walk holds an impossible date or weekday");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == B_DONE && !out_free) |=> state == B_DONE)
    else $error("result dropped while output register was busy");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == B_DONE && out_free) |=> rsp_valid)
    else $error("finished result not presented");

endmodule

FILE: tb/sv/tb_business_day_date_adder.sv
// Self-checking testbench for business_day_date_adder: walks start dates forward by
// business days in its own predictor and compares every returned date in order.
// Depends on bdda_pkg and the business_day_date_adder RTL.
`timescale 1ns / 1ps

module tb_business_day_date_adder;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  bdda_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  bdda_pkg::rsp_t rsp;

  bdda_pkg::rsp_t expected_end_dates[$];
  int unsigned words_sent;
  int unsigned dates_checked;
  int unsigned bad_dates_seen;
  int unsigned mismatches;
  int unsigned req_gap_pct;
  int unsigned rsp_stall_pct;
  int unsigned rsp_hold_request;

  business_day_date_adder DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:       len = (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
      default: len = 0;
    endcase
    return len;
  endfunction

  // Walk the calendar one day at a time, spending a day only on Sunday..Thursday.
  function automatic bdda_pkg::rsp_t predict_end_date(input bdda_pkg::req_t w);
    int unsigned y, m, d, left, wd, a, yy, mm;
    bdda_pkg::rsp_t r;
    y    = w.start_year;
    m    = w.start_month;
    d    = w.start_day;
    left = w.business_days;
    r.bad_date = (y == 0) || (m < 1) || (m > bdda_pkg::December) || (d == 0) ||
                 (d > month_days(y, m));
    if (!r.bad_date) begin
      // weekday of the start date, Sunday is 0, year shifted so March leads
      a  = (m <= 2) ? 1 : 0;
      yy = y - a;
      mm = m + 12 * a - 2;
      wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
      while (left > 0) begin
        if (wd != bdda_pkg::Friday && wd != bdda_pkg::Saturday) left--;
        if (d == month_days(y, m)) begin
          d = 1;
          if (m == bdda_pkg::December) begin
            m = 1;
            y = (y == bdda_pkg::YearMax) ? 0 : y + 1;
          end else begin
            m++;
          end
        end else begin
          d++;
        end
        wd = (wd + 1) % 7;
      end
    end
    r.end_year  = y[bdda_pkg::YearW-1:0];
    r.end_month = m[bdda_pkg::MonthW-1:0];
    r.end_day   = d[bdda_pkg::DayW-1:0];
    return r;
  endfunction

  function automatic bdda_pkg::req_t make_request(input int unsigned y, input int unsigned m,
                                                  input int unsigned d, input int unsigned c);
    bdda_pkg::req_t w;
    w.start_year    = y[bdda_pkg::YearW-1:0];
    w.start_month   = m[bdda_pkg::MonthW-1:0];
    w.start_day     = d[bdda_pkg::DayW-1:0];
    w.business_days = c[bdda_pkg::CountW-1:0];
    return w;
  endfunction

  // Mostly well-formed dates with short walks; some near the year wrap, some
  // past the month end, some raw noise, and a few long walks.
  function automatic bdda_pkg::req_t pick_request();
    int unsigned y, m, d, dim, sel, csel, c;
    sel = $urandom_range(0, 99);
    y   = $urandom_range(1, 16383);
    m   = $urandom_range(1, 12);
    dim = month_days(y, m);
    d   = $urandom_range(1, dim);
    if (sel < 6) begin
      y = bdda_pkg::YearMax;
      m = bdda_pkg::December;
      d = $urandom_range(1, 31);
    end else if (sel < 11) begin
      if (dim < 31) d = $urandom_range(dim + 1, 31);
    end else if (sel < 19) begin
      y = $urandom_range(0, 16383);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end
    csel = $urandom_range(0, 99);
    if (csel < 80)      c = $urandom_range(0, 40);
    else if (csel < 98) c = $urandom_range(0, 600);
    else                c = $urandom_range(0, 8191);
    return make_request(y, m, d, c);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 20) $display("mismatch: %s", what);
  endtask

  // Offer one word after an optional gap and hold it until accepted.
  task automatic send_word(input bdda_pkg::req_t w);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < req_gap_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_end_dates.push_back(predict_end_date(w));
    words_sent++;
  endtask

  // Receiver stall: a requested long hold first, else random bursts.
  initial begin
    int unsigned hold_left, burst_left;
    hold_left  = 0;
    burst_left = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_request > 0) begin
        hold_left        = rsp_hold_request;
        rsp_hold_request = 0;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        rsp_stall <= 1'b1;
        burst_left--;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Compare each returned word with the oldest prediction.
  initial begin
    bdda_pkg::rsp_t exp_date;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (expected_end_dates.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", dates_checked));
        end else begin
          exp_date = expected_end_dates.pop_front();
          if (rsp.end_year !== exp_date.end_year)
            report_mismatch($sformatf("result %0d end_year %0d, want %0d",
                                      dates_checked, rsp.end_year, exp_date.end_year));
          if (rsp.end_month !== exp_date.end_month)
            report_mismatch($sformatf("result %0d end_month %0d, want %0d",
                                      dates_checked, rsp.end_month, exp_date.end_month));
          if (rsp.end_day !== exp_date.end_day)
            report_mismatch($sformatf("result %0d end_day %0d, want %0d",
                                      dates_checked, rsp.end_day, exp_date.end_day));
          if (rsp.bad_date !== exp_date.bad_date)
            report_mismatch($sformatf("result %0d bad_date %b, want %b",
                                      dates_checked, rsp.bad_date, exp_date.bad_date));
          if (exp_date.bad_date) bad_dates_seen++;
        end
        dates_checked++;
      end
    end
  end

  task automatic test_zero_count();
    send_word(make_request(2024, 3, 15, 0));
    send_word(make_request(1, 1, 1, 0));
  endtask

  task automatic test_invalid_dates();
    send_word(make_request(0, 6, 10, 5));          // year zero
    send_word(make_request(2024, 0, 10, 5));       // month zero
    send_word(make_request(2024, 13, 10, 5));      // month past December
    send_word(make_request(2024, 5, 0, 5));        // day zero
    send_word(make_request(2024, 4, 31, 5));       // past a 30-day month
    send_word(make_request(1900, 2, 29, 5));       // century, not a leap year
    send_word(make_request(2024, 2, 30, 5));
  endtask

  task automatic test_month_ends();
    send_word(make_request(2024, 2, 28, 2));
    send_word(make_request(2023, 2, 28, 1));
    send_word(make_request(2000, 2, 28, 3));
    send_word(make_request(1999, 12, 31, 1));
    send_word(make_request(2024, 1, 31, 1));
  endtask

  task automatic test_weekend_starts();
    send_word(make_request(2024, 1, 5, 1));        // Friday
    send_word(make_request(2024, 1, 6, 1));        // Saturday
    send_word(make_request(2024, 1, 5, 0));
  endtask

  task automatic test_year_wrap();
    send_word(make_request(bdda_pkg::YearMax, 12, 31, 1));
    send_word(make_request(bdda_pkg::YearMax, 12, 20, 60));  // runs past Feb 29 of year zero
    send_word(make_request(9999, 12, 31, 3));
  endtask

  task automatic test_extreme_fields();
    send_word(make_request(bdda_pkg::YearMax, 15, 31, 65535));
    send_word(make_request(bdda_pkg::YearMax, 1, 31, 1));
    send_word(make_request(2024, 1, 1, 65535));
  endtask

  // Hold the result side off while words keep coming, so the input stalls.
  task automatic test_backpressure();
    req_gap_pct      = 0;
    rsp_hold_request = 400;
    repeat (12) send_word(make_request(2024, $urandom_range(1, 12), $urandom_range(1, 28),
                                       $urandom_range(0, 5)));
  endtask

  task automatic test_random_walks();
    int unsigned phase;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
        1: begin req_gap_pct = 20; rsp_stall_pct = 20; end
        2: begin req_gap_pct = 50; rsp_stall_pct = 10; end
        default: begin req_gap_pct = 10; rsp_stall_pct = 60; end
      endcase
      repeat (215) send_word(pick_request());
    end
  endtask

  initial begin
    words_sent       = 0;
    dates_checked    = 0;
    bad_dates_seen   = 0;
    mismatches       = 0;
    req_gap_pct      = 25;
    rsp_stall_pct    = 25;
    rsp_hold_request = 0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_zero_count();
    test_invalid_dates();
    test_month_ends();
    test_weekend_starts();
    test_year_wrap();
    test_extreme_fields();
    test_backpressure();
    test_random_walks();

    req_valid <= 1'b0;
    while (expected_end_dates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d words, %0d of them invalid start dates, with year wraps,",
             words_sent, bad_dates_seen);
    $display("weekend starts, long walks and a 400-cycle result hold-off");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d results still pending", expected_end_dates.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
